>>> rtl/mwmn_pkg.sv
// Shared constants, types and a helper function for the mecanum wheel mixer.
`default_nettype none
package mwmn_pkg;

	localparam int CMD_WIDTH = 16;
	localparam int SUM_W     = CMD_WIDTH + 2;
	localparam int MAG_W     = CMD_WIDTH + 1;
	localparam int OUT_W     = 16;
	localparam int Q_W       = OUT_W - 1;
	localparam int WHEELS    = 4;

	localparam logic [MAG_W-1:0] FULL_SCALE = MAG_W'(16384);

	localparam int FL = 0;
	localparam int FR = 1;
	localparam int BL = 2;
	localparam int BR = 3;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [Q_W-1:0]   quo;
		logic             nb;
	} lane_t;

	typedef struct packed {
		lane_t [WHEELS-1:0]            lane;
		logic [MAG_W-1:0]              peak;
		logic [WHEELS-1:0]             neg;
		logic [WHEELS-1:0][OUT_W-1:0]  pass;
		logic                          scaled;
	} div_t;

	function automatic logic [MAG_W-1:0] mag_f(input logic signed [SUM_W-1:0] w);
		logic [SUM_W-1:0] a;
		a = w[SUM_W-1] ? SUM_W'(-w) : SUM_W'(w);
		return a[MAG_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/mwmn_mix.sv
// Wheel sums, magnitudes and peak search, two register stages ahead of the divider.
`default_nettype none
module mwmn_mix
	import mwmn_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        up_vld,
	input  wire logic signed [CMD_WIDTH-1:0] forward_cmd,
	input  wire logic signed [CMD_WIDTH-1:0] strafe_cmd,
	input  wire logic signed [CMD_WIDTH-1:0] turn_cmd,
	output logic                             dn_vld,
	output div_t                             dn_dat
);

	logic                                  vld_s1;
	logic signed [WHEELS-1:0][SUM_W-1:0]   sum_s1;
	logic                                  vld_s2;
	div_t                                  dat_s2;

	logic signed [SUM_W-1:0]               f_x, s_x, t_x;
	logic [WHEELS-1:0][MAG_W-1:0]          mag;
	logic [MAG_W-1:0]                      pk_a, pk_b, pk;
	div_t                                  nxt;

	assign f_x = SUM_W'(forward_cmd);
	assign s_x = SUM_W'(strafe_cmd);
	assign t_x = SUM_W'(turn_cmd);

	always_comb begin
		for (int i = 0; i < WHEELS; i++) begin
			mag[i] = mag_f(sum_s1[i]);
		end
		pk_a = (mag[FL] > mag[FR]) ? mag[FL] : mag[FR];
		pk_b = (mag[BL] > mag[BR]) ? mag[BL] : mag[BR];
		pk   = (pk_a > pk_b) ? pk_a : pk_b;
		nxt.peak   = pk;
		nxt.scaled = (pk > FULL_SCALE);
		for (int i = 0; i < WHEELS; i++) begin
			nxt.neg[i]      = sum_s1[i][SUM_W-1];
			nxt.pass[i]     = sum_s1[i][OUT_W-1:0];
			nxt.lane[i].rem = mag[i] >> 1;
			nxt.lane[i].nb  = mag[i][0];
			nxt.lane[i].quo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= up_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1[FL] <= f_x + s_x + t_x;
			sum_s1[FR] <= f_x - s_x - t_x;
			sum_s1[BL] <= f_x - s_x + t_x;
			sum_s1[BR] <= f_x + s_x - t_x;
			dat_s2     <= nxt;
		end
	end

	assign dn_vld = vld_s2;
	assign dn_dat = dat_s2;

endmodule
`default_nettype wire

>>> rtl/mwmn_div_stage.sv
// One restoring-division step for all four wheels, with its pipeline register.
`default_nettype none
module mwmn_div_stage
	import mwmn_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic up_vld,
	input  wire div_t up_dat,
	output logic      dn_vld,
	output div_t      dn_dat
);

	logic vld_q;
	div_t dat_q;
	div_t nxt;

	always_comb begin
		logic [MAG_W:0] trial;
		logic [MAG_W:0] diff;
		nxt = up_dat;
		for (int i = 0; i < WHEELS; i++) begin
			trial = {up_dat.lane[i].rem, up_dat.lane[i].nb};
			diff  = trial - {1'b0, up_dat.peak};
			if (trial >= {1'b0, up_dat.peak}) begin
				nxt.lane[i].rem = diff[MAG_W-1:0];
				nxt.lane[i].quo = {up_dat.lane[i].quo[Q_W-2:0], 1'b1};
			end else begin
				nxt.lane[i].rem = trial[MAG_W-1:0];
				nxt.lane[i].quo = {up_dat.lane[i].quo[Q_W-2:0], 1'b0};
			end
			nxt.lane[i].nb = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= up_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_q <= nxt;
		end
	end

	assign dn_vld = vld_q;
	assign dn_dat = dat_q;

endmodule
`default_nettype wire

>>> rtl/mecanum_wheel_mix_normalize.sv
// Top level of the mecanum wheel mixer with peak normalisation.
// A command word passes the mixer, the divider stages and the output register.
// Throughput: one word per cycle unless stalled; the 15 single-bit divider
// stages set the depth. A stall at the output holds the whole pipeline in place.
// Reset clears every valid bit; the data registers are not reset.
`default_nettype none
module mecanum_wheel_mix_normalize
	import mwmn_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	output logic                             cmd_ready,
	input  wire logic signed [CMD_WIDTH-1:0] forward_cmd,
	input  wire logic signed [CMD_WIDTH-1:0] strafe_cmd,
	input  wire logic signed [CMD_WIDTH-1:0] turn_cmd,
	output logic                             wheel_valid,
	input  wire logic                        wheel_ready,
	output logic signed [OUT_W-1:0]          front_left_speed,
	output logic signed [OUT_W-1:0]          front_right_speed,
	output logic signed [OUT_W-1:0]          back_left_speed,
	output logic signed [OUT_W-1:0]          back_right_speed,
	output logic                             was_scaled
);

	logic                          en;
	logic [Q_W:0]                  stg_vld;
	div_t [Q_W:0]                  stg_dat;
	logic                          out_vld_q;
	logic [WHEELS-1:0][OUT_W-1:0]  spd_q;
	logic                          scaled_q;
	logic [WHEELS-1:0][OUT_W-1:0]  spd_nxt;

	assign en        = !out_vld_q || wheel_ready;
	assign cmd_ready = en;

	mwmn_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.up_vld      (cmd_valid),
		.forward_cmd (forward_cmd),
		.strafe_cmd  (strafe_cmd),
		.turn_cmd    (turn_cmd),
		.dn_vld      (stg_vld[0]),
		.dn_dat      (stg_dat[0])
	);

	for (genvar g = 0; g < Q_W; g++) begin : g_div
		mwmn_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.up_vld (stg_vld[g]),
			.up_dat (stg_dat[g]),
			.dn_vld (stg_vld[g+1]),
			.dn_dat (stg_dat[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < WHEELS; i++) begin
			if (stg_dat[Q_W].scaled) begin
				spd_nxt[i] = stg_dat[Q_W].neg[i] ? OUT_W'(-{1'b0, stg_dat[Q_W].lane[i].quo})
					: {1'b0, stg_dat[Q_W].lane[i].quo};
			end else begin
				spd_nxt[i] = stg_dat[Q_W].pass[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= stg_vld[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spd_q    <= spd_nxt;
			scaled_q <= stg_dat[Q_W].scaled;
		end
	end

	assign wheel_valid       = out_vld_q;
	assign front_left_speed  = spd_q[FL];
	assign front_right_speed = spd_q[FR];
	assign back_left_speed   = spd_q[BL];
	assign back_right_speed  = spd_q[BR];
	assign was_scaled        = scaled_q;

	// The delivered front left and back right wheel speeds lie within full scale.
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wheel_valid |-> (front_left_speed >= -16'sd16384 && front_left_speed <= 16'sd16384 &&
			back_right_speed >= -16'sd16384 && back_right_speed <= 16'sd16384))
		else $error("wheel speed beyond full scale");

	// After scaling, the wheel that set the peak lands exactly on full scale.
	a_peak_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(wheel_valid && was_scaled) |->
			(front_left_speed == 16'sd16384 || front_left_speed == -16'sd16384 ||
			front_right_speed == 16'sd16384 || front_right_speed == -16'sd16384 ||
			back_left_speed == 16'sd16384 || back_left_speed == -16'sd16384 ||
			back_right_speed == 16'sd16384 || back_right_speed == -16'sd16384))
		else $error("scaled word has no wheel at full scale");

	// A word taken from the last divider stage reaches the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(stg_vld[Q_W] && en) |=> wheel_valid)
		else $error("word lost between divider and output register");

endmodule
`default_nettype wire

>>> tb/sv/tb_mecanum_wheel_mix_normalize.sv
// Self-checking testbench for the mecanum wheel mixer with peak normalisation.
`timescale 1ns / 100ps
module tb_mecanum_wheel_mix_normalize;
	import mwmn_pkg::*;

	typedef logic signed [CMD_WIDTH-1:0] cmd_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] fl;
		logic signed [OUT_W-1:0] fr;
		logic signed [OUT_W-1:0] bl;
		logic signed [OUT_W-1:0] br;
		logic                    scaled;
	} wheel_word_t;

	localparam longint UNIT_SPEED = 16384;

	logic                    clk;
	logic                    arst_n;
	logic                    cmd_valid;
	logic                    cmd_ready;
	cmd_t                    forward_cmd;
	cmd_t                    strafe_cmd;
	cmd_t                    turn_cmd;
	logic                    wheel_valid;
	logic                    wheel_ready;
	logic signed [OUT_W-1:0] front_left_speed;
	logic signed [OUT_W-1:0] front_right_speed;
	logic signed [OUT_W-1:0] back_left_speed;
	logic signed [OUT_W-1:0] back_right_speed;
	logic                    was_scaled;

	wheel_word_t expected_wheels[$];
	int          wheel_mismatches = 0;
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;

	mecanum_wheel_mix_normalize dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_valid         (cmd_valid),
		.cmd_ready         (cmd_ready),
		.forward_cmd       (forward_cmd),
		.strafe_cmd        (strafe_cmd),
		.turn_cmd          (turn_cmd),
		.wheel_valid       (wheel_valid),
		.wheel_ready       (wheel_ready),
		.front_left_speed  (front_left_speed),
		.front_right_speed (front_right_speed),
		.back_left_speed   (back_left_speed),
		.back_right_speed  (back_right_speed),
		.was_scaled        (was_scaled)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_mecanum_wheel_mix_normalize NOT OK");
		$finish;
	end

	function automatic wheel_word_t mix_wheels(input cmd_t f, input cmd_t s, input cmd_t t);
		longint      sum[WHEELS];
		longint      peak;
		longint      m;
		wheel_word_t w;
		sum[FL] = longint'(f) + longint'(s) + longint'(t);
		sum[FR] = longint'(f) - longint'(s) - longint'(t);
		sum[BL] = longint'(f) - longint'(s) + longint'(t);
		sum[BR] = longint'(f) + longint'(s) - longint'(t);
		peak = 0;
		for (int i = 0; i < WHEELS; i++) begin
			m = (sum[i] < 0) ? -sum[i] : sum[i];
			if (m > peak)
				peak = m;
		end
		w.scaled = (peak > UNIT_SPEED);
		if (w.scaled) begin
			for (int i = 0; i < WHEELS; i++)
				sum[i] = (sum[i] * UNIT_SPEED) / peak;
		end
		w.fl = OUT_W'(sum[FL]);
		w.fr = OUT_W'(sum[FR]);
		w.bl = OUT_W'(sum[BL]);
		w.br = OUT_W'(sum[BR]);
		return w;
	endfunction

	function automatic cmd_t rand_cmd(input int lo, input int hi);
		int r;
		r = int'($urandom_range(0, hi - lo)) + lo;
		return CMD_WIDTH'(r);
	endfunction

	task automatic send_command(input cmd_t f, input cmd_t s, input cmd_t t);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		forward_cmd <= f;
		strafe_cmd  <= s;
		turn_cmd    <= t;
		cmd_valid   <= 1'b1;
		@(posedge clk);
		while (!(cmd_valid && cmd_ready))
			@(posedge clk);
		expected_wheels.push_back(mix_wheels(f, s, t));
	endtask

	// Each wheel word is drawn its own stall before the output is made ready.
	initial begin : wheel_sink
		int stall;
		wheel_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				@(negedge clk);
				wheel_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			wheel_ready <= 1'b1;
			@(posedge clk);
			while (!(wheel_valid && wheel_ready))
				@(posedge clk);
		end
	end

	task automatic report_mismatch(input string why, input wheel_word_t want,
			input wheel_word_t got);
		wheel_mismatches++;
		if (wheel_mismatches <= 10)
			$display("%0t: %s: expected fl=%0d fr=%0d bl=%0d br=%0d scaled=%0b, got fl=%0d fr=%0d bl=%0d br=%0d scaled=%0b",
				$realtime, why, want.fl, want.fr, want.bl, want.br, want.scaled,
				got.fl, got.fr, got.bl, got.br, got.scaled);
	endtask

	always @(posedge clk) begin : wheel_check
		wheel_word_t got;
		wheel_word_t want;
		if (arst_n && wheel_valid && wheel_ready) begin
			got.fl     = front_left_speed;
			got.fr     = front_right_speed;
			got.bl     = back_left_speed;
			got.br     = back_right_speed;
			got.scaled = was_scaled;
			if (expected_wheels.size() == 0) begin
				want = '0;
				report_mismatch("unexpected wheel word", want, got);
			end else begin
				want = expected_wheels.pop_front();
				if (got.fl !== want.fl || got.fr !== want.fr || got.bl !== want.bl ||
						got.br !== want.br || got.scaled !== want.scaled)
					report_mismatch("wheel word mismatch", want, got);
			end
		end
	end

	task automatic test_corner_commands();
		send_command(0, 0, 0);
		send_command(16384, 0, 0);
		send_command(-16384, 0, 0);
		send_command(16385, 0, 0);
		send_command(0, 16384, 0);
		send_command(0, 0, -16384);
		send_command(32767, 0, 0);
		send_command(-32768, 0, 0);
		send_command(0, -32768, 0);
		send_command(0, 0, 32767);
		send_command(32767, 32767, 32767);
		send_command(-32768, -32768, -32768);
		send_command(32767, -32768, 32767);
		send_command(-32768, 32767, -32768);
		send_command(32767, 32767, -32768);
		send_command(8192, 8192, 0);
		send_command(8192, 8192, 1);
		send_command(5461, 5461, 5462);
		send_command(-5461, -5461, -5462);
		send_command(1, -1, 1);
		send_command(-1, 0, 0);
		send_command(10000, -3000, 7000);
		send_command(12000, -12000, 0);
		send_command(-1, -1, -1);
	endtask

	// Small commands keep every wheel sum within full scale.
	task automatic test_passthrough_random(input int count);
		repeat (count)
			send_command(rand_cmd(-5461, 5461), rand_cmd(-5461, 5461), rand_cmd(-5461, 5461));
	endtask

	task automatic test_scaled_random(input int count);
		repeat (count)
			send_command(rand_cmd(-32768, 32767), rand_cmd(-32768, 32767),
				rand_cmd(-32768, 32767));
	endtask

	// The front left sum is steered to within three of full scale, either sign.
	task automatic test_full_scale_edge(input int count);
		int s;
		int t;
		int f;
		repeat (count) begin
			s = $urandom_range(0, 4000);
			t = $urandom_range(0, 4000);
			f = 16384 - s - t + int'($urandom_range(0, 6)) - 3;
			if ($urandom_range(0, 1))
				send_command(CMD_WIDTH'(-f), CMD_WIDTH'(-s), CMD_WIDTH'(-t));
			else
				send_command(CMD_WIDTH'(f), CMD_WIDTH'(s), CMD_WIDTH'(t));
		end
	endtask

	task automatic test_back_to_back(input int count);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		test_scaled_random(count);
		rx_steady = 1'b0;
		test_passthrough_random(count);
		tx_steady = 1'b0;
		rx_steady = 1'b1;
		test_scaled_random(count);
		rx_steady = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		forward_cmd = '0;
		strafe_cmd  = '0;
		turn_cmd    = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_corner_commands();
		test_passthrough_random(220);
		test_scaled_random(250);
		test_full_scale_edge(160);
		test_back_to_back(70);

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (expected_wheels.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (wheel_mismatches == 0 && expected_wheels.size() == 0)
			$display("tb_mecanum_wheel_mix_normalize OK");
		else
			$display("tb_mecanum_wheel_mix_normalize NOT OK");
		$finish;
	end

endmodule
